// ===== rtl/taa_pkg.sv =====
// Shared types and constants for the table arctangent angle core.
// Used by the front end, the item queue, the back end and the top level.
`timescale 1ns / 1ps

package taa_pkg;

  localparam int unsigned FRACTION_BITS_DEFAULT = 10;
  localparam int unsigned QUEUE_DEPTH = 4;

  localparam logic OP_COMPUTE = 1'b0;
  localparam logic OP_WRITE   = 1'b1;

  localparam logic [15:0] QUARTER_TURN       = 16'h4000;
  localparam logic [15:0] THREE_QUARTER_TURN = 16'hC000;

  // Quadrant code: bit 0 set for negative y, bit 1 set for negative x.
  localparam logic [1:0] QUAD_YPOS_XPOS = 2'd0;
  localparam logic [1:0] QUAD_YNEG_XPOS = 2'd1;
  localparam logic [1:0] QUAD_YPOS_XNEG = 2'd2;
  localparam logic [1:0] QUAD_YNEG_XNEG = 2'd3;

  // One classified word as it waits between front and back.
  typedef struct packed {
    logic        is_write;
    logic        zero;
    logic        x_larger;
    logic [1:0]  quad;
    logic [31:0] num;
    logic [31:0] den;
    logic [10:0] entry_index;
    logic [15:0] entry_angle;
  } item_t;

  // Status of the queue as seen by the top level.
  typedef struct packed {
    logic head_valid;
    logic full;
  } queue_status_t;

endpackage

// ===== rtl/taa_front.sv =====
// Front end: takes magnitudes and signs, picks numerator and divisor.
// Depends on taa_pkg for the item type and operation codes.
`timescale 1ns / 1ps

module taa_front #(
  parameter int unsigned FRACTION_BITS = taa_pkg::FRACTION_BITS_DEFAULT
) (
  input  logic               op,
  input  logic signed [31:0] y_value,
  input  logic signed [31:0] x_value,
  input  logic [10:0]        entry_index,
  input  logic [15:0]        entry_angle,
  output taa_pkg::item_t     item
);
  import taa_pkg::*;

  logic [31:0] ay;
  logic [31:0] ax;
  logic        y_larger;
  logic [31:0] small_mag;

  always_comb begin
    ay = y_value[31] ? 32'(-y_value) : 32'(y_value);
    ax = x_value[31] ? 32'(-x_value) : 32'(x_value);
    // Equal magnitudes count as y being the larger.
    y_larger  = (ay >= ax);
    small_mag = y_larger ? ax : ay;

    item.is_write    = (op == OP_WRITE);
    item.zero        = y_larger && (ay == 32'd0);
    item.x_larger    = !y_larger;
    item.quad        = {x_value[31], y_value[31]};
    item.num         = 32'(small_mag << FRACTION_BITS);
    item.den         = y_larger ? ay : ax;
    item.entry_index = entry_index;
    item.entry_angle = entry_angle;
  end

endmodule

// ===== rtl/taa_queue.sv =====
// Short first-in first-out queue of classified words between front and back.
// Depends on taa_pkg for the item and status types.
`timescale 1ns / 1ps

module taa_queue (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  input  taa_pkg::item_t         push_item,
  input  logic                   pop,
  output taa_pkg::item_t         head_item,
  output taa_pkg::queue_status_t status
);
  import taa_pkg::*;

  localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);

  item_t              slots [QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [PTR_W:0]     count;
  logic               do_pop;

  assign do_pop            = pop && (count != '0);
  assign status.head_valid = (count != '0);
  assign status.full       = (count == (PTR_W+1)'(QUEUE_DEPTH));
  assign head_item         = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + (PTR_W+1)'(push) - (PTR_W+1)'(do_pop);
    end
  end

endmodule

// ===== rtl/taa_back.sv =====
// Back end: pipelined restoring divider, arctangent table and quadrant fold.
// Depends on taa_pkg for the item type, angles and quadrant codes.
`timescale 1ns / 1ps

module taa_back #(
  parameter int unsigned FRACTION_BITS = taa_pkg::FRACTION_BITS_DEFAULT
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  input  taa_pkg::item_t in_item,
  output logic           done,
  output logic [15:0]    angle,
  output logic           div_zero
);
  import taa_pkg::*;

  localparam int unsigned QW    = FRACTION_BITS + 1;
  localparam int unsigned DEPTH = (1 << FRACTION_BITS) + 1;

  // Divider stages, one quotient bit each, most significant first.
  logic          vld_s [QW];
  item_t         it_s  [QW];
  logic [31:0]   rem_s [QW];
  logic [QW-1:0] quo_s [QW];

  for (genvar k = 0; k < QW; k++) begin : g_div
    logic          vld_src;
    item_t         it_src;
    logic [31:0]   rem_src;
    logic [QW-1:0] quo_src;
    logic [32:0]   trial;
    logic [32:0]   diff;
    logic          ge;

    if (k == 0) begin : g_first
      assign vld_src = in_valid;
      assign it_src  = in_item;
      assign rem_src = 32'(in_item.num >> QW);
      assign quo_src = '0;
    end else begin : g_next
      assign vld_src = vld_s[k-1];
      assign it_src  = it_s[k-1];
      assign rem_src = rem_s[k-1];
      assign quo_src = quo_s[k-1];
    end

    assign trial = {rem_src, it_src.num[FRACTION_BITS-k]};
    assign diff  = trial - {1'b0, it_src.den};
    assign ge    = (trial >= {1'b0, it_src.den});

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_s[k] <= 1'b0;
      end else begin
        vld_s[k] <= vld_src;
      end
    end

    always_ff @(posedge clk) begin
      it_s[k]  <= it_src;
      rem_s[k] <= ge ? diff[31:0] : trial[31:0];
      quo_s[k] <= {quo_src[QW-2:0], ge};
    end
  end

  // Table stage: writes and reads keep item order through one port.
  logic [15:0] atan_table [DEPTH];
  logic [31:0] wr_wide;
  logic        wr_ok;
  logic        tbl_vld;
  logic        tbl_zero;
  logic        tbl_xl;
  logic [1:0]  tbl_quad;
  logic [15:0] tbl_data;

  assign wr_wide = 32'(it_s[QW-1].entry_index);
  assign wr_ok   = (wr_wide < 32'(DEPTH));

  always_ff @(posedge clk) begin
    if (vld_s[QW-1]) begin
      if (it_s[QW-1].is_write) begin
        if (wr_ok) begin
          atan_table[wr_wide[QW-1:0]] <= it_s[QW-1].entry_angle;
        end
      end else if (!it_s[QW-1].zero) begin
        tbl_data <= atan_table[quo_s[QW-1]];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tbl_vld <= 1'b0;
    end else begin
      tbl_vld <= vld_s[QW-1] && !it_s[QW-1].is_write;
    end
  end

  always_ff @(posedge clk) begin
    tbl_zero <= it_s[QW-1].zero;
    tbl_xl   <= it_s[QW-1].x_larger;
    tbl_quad <= it_s[QW-1].quad;
  end

  // Output stage: reflection and quadrant offset, all modulo one turn.
  logic [15:0] base;
  logic [15:0] folded;

  always_comb begin
    base = tbl_xl ? (QUARTER_TURN - tbl_data) : tbl_data;
    unique case (tbl_quad)
      QUAD_YPOS_XPOS: folded = base - QUARTER_TURN;
      QUAD_YNEG_XPOS: folded = QUARTER_TURN - base;
      QUAD_YPOS_XNEG: folded = THREE_QUARTER_TURN - base;
      QUAD_YNEG_XNEG: folded = base + QUARTER_TURN;
      default:        folded = base;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= tbl_vld;
    end
  end

  always_ff @(posedge clk) begin
    angle    <= tbl_zero ? 16'h0000 : folded;
    div_zero <= tbl_zero;
  end

endmodule

// ===== rtl/table_atan2_angle_core.sv =====
// Top level of the table arctangent angle core.
// Depends on taa_pkg, taa_front, taa_queue and taa_back.
`timescale 1ns / 1ps

// Four-quadrant angle core. A word is taken at each rising edge where start
// is high and busy is low; op selects between an angle computation and a
// write of one arctangent table entry. Words are accepted one per clock
// cycle, back to back, while busy stays low. A computation returns its angle
// and divide-by-zero flag after passing the queue register, the divider,
// which resolves one quotient bit per pipeline stage, the registered table
// read and the output register, marked by done for exactly one cycle;
// results leave in the order the words came in and cannot be held off.
// Table writes travel the same pipeline, so a computation always sees
// every write accepted before it and none after; a write returns nothing.
// The table must be filled before it is used, as its contents are undefined
// after reset. Busy rises only if the internal queue fills, which the back
// end, draining one word every cycle, never lets happen in normal use.
module table_atan2_angle_core #(
  parameter int unsigned FRACTION_BITS = taa_pkg::FRACTION_BITS_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic               op,
  input  logic signed [31:0] y_value,
  input  logic signed [31:0] x_value,
  input  logic [10:0]        entry_index,
  input  logic [15:0]        entry_angle,
  output logic               done,
  output logic [15:0]        angle,
  output logic               div_zero
);
  import taa_pkg::*;

  item_t         front_item;
  item_t         head_item;
  queue_status_t q_status;
  logic          accept;

  // The queue full flag is the only thing that can refuse a word.
  assign busy   = q_status.full;
  assign accept = start && !busy;

  // Magnitudes, quadrant and divider operands are worked out on the way in.
  taa_front #(
    .FRACTION_BITS(FRACTION_BITS)
  ) u_front (
    .op          (op),
    .y_value     (y_value),
    .x_value     (x_value),
    .entry_index (entry_index),
    .entry_angle (entry_angle),
    .item        (front_item)
  );

  taa_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (accept),
    .push_item (front_item),
    .pop       (q_status.head_valid),
    .head_item (head_item),
    .status    (q_status)
  );

  // The back end never stalls, so the queue head is taken whenever present.
  taa_back #(
    .FRACTION_BITS(FRACTION_BITS)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .in_valid (q_status.head_valid),
    .in_item  (head_item),
    .done     (done),
    .angle    (angle),
    .div_zero (div_zero)
  );

endmodule
